// ----- rtl/core/btcp_pkg.sv -----
`timescale 1ns / 1ps
package btcp_pkg;

    localparam logic [1:0] KIND_TBL_LEAF = 2'd0;
    localparam logic [1:0] KIND_TBL_INT  = 2'd1;
    localparam logic [1:0] KIND_IDX_LEAF = 2'd2;
    localparam logic [1:0] KIND_IDX_INT  = 2'd3;

    localparam logic CFG_PAGE_KIND = 1'b0;
    localparam logic CFG_USABLE    = 1'b1;

    localparam logic [16:0] USABLE_RESET = 17'd4096;
    localparam logic [16:0] USABLE_MIN   = 17'd480;
    localparam logic [16:0] USABLE_MAX   = 17'd65536;
    localparam logic [16:0] TBL_OVERHEAD = 17'd35;
    localparam logic [16:0] IDX_OVERHEAD = 17'd12;
    localparam logic [16:0] LIMIT_BIAS   = 17'd23;
    localparam logic [16:0] PTR_BYTES    = 17'd4;
    // ceil(2^30 / 255), exact floor divide by 255 below 2^22
    localparam logic [22:0] RECIP_255    = 23'd4210753;
    localparam int          RECIP_SHIFT  = 30;

    typedef struct packed {
        logic start;
        logic cut_set;
        logic byte8;
        logic vbyte;
        logic hcount;
        logic take_child;
        logic take_payload;
        logic take_key;
        logic lim_load;
        logic cmp_load;
        logic fit_take;
        logic div_start;
        logic k_take;
        logic skip_dec;
        logic emit;
        logic emit_spill;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       idx3;
        logic       idx3_held;
        logic       vdone;
        logic       skip_le1;
        logic       fits;
        logic       div_done;
        logic       k_zero;
        logic       out_free;
    } t_sts;

endpackage

// ----- rtl/core/btcp_mod.sv -----
`timescale 1ns / 1ps
module btcp_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [16:0] o_rem
);
    import btcp_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_q;
    logic [16:0] r_rem;
    logic [16:0] r_div;

    logic [18:0] w_t;
    logic [18:0] w_d1;
    logic [18:0] w_d2;
    logic [18:0] w_d3;
    logic [18:0] w_res;

    // radix-4 restoring step, two dividend bits per cycle
    always_comb begin
        w_t  = {r_rem, r_q[63:62]};
        w_d1 = {2'b00, r_div};
        w_d2 = {1'b0, r_div, 1'b0};
        w_d3 = w_d1 + w_d2;
        priority if (w_t >= w_d3) begin
            w_res = w_t - w_d3;
        end else if (w_t >= w_d2) begin
            w_res = w_t - w_d2;
        end else if (w_t >= w_d1) begin
            w_res = w_t - w_d1;
        end else begin
            w_res = w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= 17'd0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[61:0], 2'b00};
            r_rem <= w_res[16:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/btcp_dpath.sv -----
`timescale 1ns / 1ps
module btcp_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [16:0]     i_cfg_data,
    input  logic [7:0]      i_data_byte,
    input  logic [15:0]     i_cell_offset,
    input  btcp_pkg::t_cmd  i_cmd,
    output btcp_pkg::t_sts  o_sts,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [31:0]     o_child_page,
    output logic [63:0]     o_row_key,
    output logic [63:0]     o_payload_total,
    output logic [16:0]     o_local_count,
    output logic [16:0]     o_payload_start,
    output logic [31:0]     o_spill_page,
    output logic            o_restarted
);
    import btcp_pkg::*;

    logic [1:0]  r_kind;
    logic [16:0] r_usable;
    logic [63:0] r_acc,   n_acc;
    logic [3:0]  r_idx,   n_idx;
    logic [4:0]  r_hlen,  n_hlen;
    logic [15:0] r_off,   n_off;
    logic [31:0] r_child, n_child;
    logic [63:0] r_key,   n_key;
    logic [63:0] r_pay,   n_pay;
    logic [16:0] r_local, n_local;
    logic [16:0] r_skip,  n_skip;
    logic        r_cut;
    logic [45:0] r_prod;
    logic [16:0] r_maxl;
    logic [16:0] r_minl;
    logic        r_out_valid;

    logic [63:0] w_acc_base;
    logic [3:0]  w_idx_base;
    logic [4:0]  w_hlen_base;
    logic [16:0] w_u;
    logic [22:0] w_a64;
    logic [15:0] w_q64;
    logic [16:0] w_maxl;
    logic [16:0] w_minl;
    logic [16:0] w_rem;
    logic        w_div_done;
    logic [17:0] w_ksum;
    logic [16:0] w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_TBL_LEAF;
            r_usable <= USABLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAGE_KIND: r_kind   <= i_cfg_data[1:0];
                CFG_USABLE:    r_usable <= i_cfg_data;
                default:       r_kind   <= r_kind;
            endcase
        end
    end

    always_comb begin
        priority if (r_usable < USABLE_MIN) begin
            w_u = USABLE_MIN;
        end else if (r_usable > USABLE_MAX) begin
            w_u = USABLE_MAX;
        end else begin
            w_u = r_usable;
        end
    end

    assign w_a64 = {w_u - IDX_OVERHEAD, 6'b000000};
    assign w_q64 = r_prod[45:RECIP_SHIFT];
    assign w_minl = {2'b00, w_q64[15:1]} - LIMIT_BIAS;
    assign w_maxl = (r_kind == KIND_TBL_LEAF || r_kind == KIND_TBL_INT)
                  ? (w_u - TBL_OVERHEAD) : ({1'b0, w_q64} - LIMIT_BIAS);

    btcp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_pay - {47'd0, w_minl}),
        .i_divisor  (w_u - PTR_BYTES),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_ksum = {1'b0, r_minl} + {1'b0, w_rem};
    assign w_k    = (w_ksum > {1'b0, r_maxl}) ? r_minl : w_ksum[16:0];

    always_comb begin
        w_acc_base  = i_cmd.start ? 64'd0 : r_acc;
        w_idx_base  = i_cmd.start ? 4'd0  : r_idx;
        w_hlen_base = i_cmd.start ? 5'd0  : r_hlen;
        n_acc   = w_acc_base;
        n_idx   = w_idx_base;
        n_hlen  = w_hlen_base;
        n_off   = i_cmd.start ? i_cell_offset : r_off;
        n_child = i_cmd.start ? 32'd0 : r_child;
        n_key   = i_cmd.start ? 64'd0 : r_key;
        n_pay   = i_cmd.start ? 64'd0 : r_pay;
        n_local = i_cmd.start ? 17'd0 : r_local;
        n_skip  = i_cmd.start ? 17'd0 : r_skip;
        if (i_cmd.byte8) begin
            n_acc = {w_acc_base[55:0], i_data_byte};
            n_idx = w_idx_base + 4'd1;
        end
        if (i_cmd.vbyte) begin
            if (w_idx_base >= 4'd8) begin
                n_acc = {w_acc_base[55:0], i_data_byte};
            end else begin
                n_acc = {w_acc_base[56:0], i_data_byte[6:0]};
                n_idx = w_idx_base + 4'd1;
            end
        end
        if (i_cmd.hcount) begin
            n_hlen = w_hlen_base + 5'd1;
        end
        if (i_cmd.take_child)   n_child = n_acc[31:0];
        if (i_cmd.take_payload) n_pay   = n_acc;
        if (i_cmd.take_key)     n_key   = n_acc;
        if (i_cmd.fit_take)     n_local = r_pay[16:0];
        if (i_cmd.k_take) begin
            n_local = w_k;
            n_skip  = w_k;
        end
        if (i_cmd.skip_dec && r_skip != 17'd0) begin
            n_skip = r_skip - 17'd1;
        end
        if (i_cmd.take_child || i_cmd.take_payload || i_cmd.take_key || i_cmd.k_take) begin
            n_acc = 64'd0;
            n_idx = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 4'd0;
            r_hlen      <= 5'd0;
            r_cut       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_hlen <= n_hlen;
            if (i_cmd.emit) begin
                r_cut <= 1'b0;
            end else if (i_cmd.cut_set) begin
                r_cut <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_off   <= n_off;
        r_child <= n_child;
        r_key   <= n_key;
        r_pay   <= n_pay;
        r_local <= n_local;
        r_skip  <= n_skip;
        if (i_cmd.lim_load) begin
            r_prod <= 46'(w_a64 * RECIP_255);
        end
        if (i_cmd.cmp_load) begin
            r_maxl <= w_maxl;
            r_minl <= w_minl;
        end
        if (i_cmd.emit) begin
            o_child_page    <= n_child;
            o_row_key       <= n_key;
            o_payload_total <= n_pay;
            o_local_count   <= n_local;
            o_payload_start <= {1'b0, n_off} + {12'd0, n_hlen};
            o_spill_page    <= i_cmd.emit_spill ? n_acc[31:0] : 32'd0;
            o_restarted     <= r_cut;
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.idx3      = (w_idx_base == 4'd3);
        // registered count only, feeds the input stall
        o_sts.idx3_held = (r_idx == 4'd3);
        o_sts.vdone     = (w_idx_base >= 4'd8) || !i_data_byte[7];
        o_sts.skip_le1  = (r_skip <= 17'd1);
        o_sts.fits      = (r_pay <= {47'd0, w_maxl});
        o_sts.div_done  = w_div_done;
        o_sts.k_zero    = (w_k == 17'd0);
        o_sts.out_free  = !r_out_valid || !i_stall;
    end

endmodule

// ----- rtl/core/btcp_ctrl.sv -----
`timescale 1ns / 1ps
module btcp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_cell_start,
    output logic            o_stall,
    input  btcp_pkg::t_sts  i_sts,
    output btcp_pkg::t_cmd  o_cmd
);
    import btcp_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHILD = 10'b0000000010,
        S_PSIZE = 10'b0000000100,
        S_KEY   = 10'b0000001000,
        S_LIM   = 10'b0000010000,
        S_CMP   = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_FIN   = 10'b0010000000,
        S_SKIP  = 10'b0100000000,
        S_OVF   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_state w_phase;
    logic   w_busy;
    logic   w_may_emit;
    logic   w_acc;
    logic   w_interior;

    assign w_interior = (i_sts.kind == KIND_TBL_INT) || (i_sts.kind == KIND_IDX_INT);
    assign w_busy = (r_state == S_LIM) || (r_state == S_CMP)
                 || (r_state == S_DIV) || (r_state == S_FIN);
    // beats that can finish a header need room in the output register
    assign w_may_emit = !i_cell_start
        && (((r_state == S_KEY) && (i_sts.kind == KIND_TBL_INT))
            || ((r_state == S_OVF) && i_sts.idx3_held));
    assign o_stall = w_busy || (w_may_emit && !i_sts.out_free);
    assign w_acc   = i_valid && !o_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        w_phase = r_state;
        if (w_acc && i_cell_start) begin
            o_cmd.start   = 1'b1;
            o_cmd.cut_set = (r_state != S_IDLE);
            w_phase       = w_interior ? S_CHILD : S_PSIZE;
            n_state       = w_phase;
        end
        unique case (w_phase)
            S_CHILD: begin
                if (w_acc) begin
                    o_cmd.byte8  = 1'b1;
                    o_cmd.hcount = 1'b1;
                    if (i_sts.idx3) begin
                        o_cmd.take_child = 1'b1;
                        n_state = (i_sts.kind == KIND_TBL_INT) ? S_KEY : S_PSIZE;
                    end
                end
            end
            S_PSIZE: begin
                if (w_acc) begin
                    o_cmd.vbyte  = 1'b1;
                    o_cmd.hcount = 1'b1;
                    if (i_sts.vdone) begin
                        o_cmd.take_payload = 1'b1;
                        n_state = (i_sts.kind == KIND_TBL_LEAF) ? S_KEY : S_LIM;
                    end
                end
            end
            S_KEY: begin
                if (w_acc) begin
                    o_cmd.vbyte  = 1'b1;
                    o_cmd.hcount = 1'b1;
                    if (i_sts.vdone) begin
                        o_cmd.take_key = 1'b1;
                        if (i_sts.kind == KIND_TBL_INT) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_LIM;
                        end
                    end
                end
            end
            S_LIM: begin
                o_cmd.lim_load = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_load = 1'b1;
                if (i_sts.fits) begin
                    o_cmd.fit_take = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.k_take = 1'b1;
                    n_state = i_sts.k_zero ? S_OVF : S_SKIP;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SKIP: begin
                if (w_acc) begin
                    o_cmd.skip_dec = 1'b1;
                    if (i_sts.skip_le1) begin
                        n_state = S_OVF;
                    end
                end
            end
            S_OVF: begin
                if (w_acc) begin
                    o_cmd.byte8 = 1'b1;
                    if (i_sts.idx3) begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_spill = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = n_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_lim_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIM) |=> (r_state == S_CMP))
        else $error("limit stage not followed by compare");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result written while output register is held");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == S_DIV))
        else $error("modulo start without wait state");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> (o_stall && !o_cmd.start))
        else $error("beat taken during spill calculation");
`endif

endmodule

// ----- rtl/core/btree_cell_header_parser.sv -----
`timescale 1ns / 1ps
// b-tree cell header parser
// input channel: one cell byte per beat (i_valid / o_stall), i_cell_start marks
//   the first byte of a cell and carries i_cell_offset
// output channel: one header result per cell (o_valid / i_stall), held in an
//   output register until taken
// config: i_cfg_we with i_cfg_idx 0 page kind, 1 usable size; write only when idle
// header bytes (child pointer, varints, overflow pointer, skipped payload) are
//   taken at one per cycle while the input is not stalled
// once the payload size is known (and on a table leaf the key) the input stalls for
//   the spill calculation: limit and compare, then the finish state when the payload
//   fits, else the 32-step radix-4 modulo unit on the 64-bit payload size
// a result leaves in the cycle after the byte that completes the header; when the
//   payload fits it leaves once the finish state finds the output register free
// a stalled output holds its result; a table interior key byte or the last overflow
//   pointer byte is stalled until the register frees, other bytes keep flowing
// a cell start in mid header drops the partial cell and flags restarted
// reset (synchronous, active low) returns to idle, page kind 0, usable size 4096
module btree_cell_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cell_start,
    input  logic [15:0] i_cell_offset,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_child_page,
    output logic [63:0] o_row_key,
    output logic [63:0] o_payload_total,
    output logic [16:0] o_local_count,
    output logic [16:0] o_payload_start,
    output logic [31:0] o_spill_page,
    output logic        o_restarted
);
    import btcp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    btcp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_cell_start (i_cell_start),
        .o_stall      (o_stall),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    btcp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_data_byte),
        .i_cell_offset   (i_cell_offset),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_child_page    (o_child_page),
        .o_row_key       (o_row_key),
        .o_payload_total (o_payload_total),
        .o_local_count   (o_local_count),
        .o_payload_start (o_payload_start),
        .o_spill_page    (o_spill_page),
        .o_restarted     (o_restarted)
    );

endmodule

// ----- tb/tb_btree_cell_header_parser.sv -----
`timescale 1ns / 1ps
module tb_btree_cell_header_parser;
    import btcp_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        start;
        logic [15:0] offset;
    } t_beat;

    typedef struct {
        logic [31:0] child;
        logic [63:0] key;
        logic [63:0] total;
        logic [16:0] local_cnt;
        logic [16:0] pstart;
        logic [31:0] spill;
        logic        restarted;
    } t_hdr;

    typedef enum logic [2:0] {
        P_IDLE, P_CHILD, P_PSIZE, P_KEY, P_SKIP, P_OVF
    } t_parse_ph;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [16:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_cell_start;
    logic [15:0] i_cell_offset;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_child_page;
    logic [63:0] o_row_key;
    logic [63:0] o_payload_total;
    logic [16:0] o_local_count;
    logic [16:0] o_payload_start;
    logic [31:0] o_spill_page;
    logic        o_restarted;

    btree_cell_header_parser dut (.*);

    t_beat beat_q[$];
    t_hdr  hdr_exp_q[$];
    int    errors = 0;
    int    snd_idle_pct = 0;
    int    rcv_idle_pct = 0;
    int    phase_beats = 0;
    longint unsigned cycles = 0;

    // predictor state
    logic [1:0]  m_kind;
    logic [16:0] m_usable;
    t_parse_ph   m_ph;
    logic [63:0] m_accum;
    int unsigned m_vidx;
    int unsigned m_hlen;
    logic [15:0] m_off;
    logic [31:0] m_child;
    logic [63:0] m_key;
    logic [63:0] m_total;
    logic [16:0] m_local;
    int unsigned m_skip;
    logic        m_cut;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] stored_bytes(logic [1:0] kind, logic [16:0] usz,
                                                 logic [63:0] p);
        logic [63:0] u;
        logic [63:0] maxl;
        logic [63:0] minl;
        logic [63:0] k;
        u = usz;
        if (u < 480) u = 480;
        if (u > 65536) u = 65536;
        if (kind == KIND_TBL_LEAF || kind == KIND_TBL_INT)
            maxl = u - 35;
        else
            maxl = ((u - 12) * 64 / 255) - 23;
        if (p <= maxl) return p;
        minl = ((u - 12) * 32 / 255) - 23;
        k = minl + ((p - minl) % (u - 4));
        if (k > maxl) k = minl;
        return k;
    endfunction

    task automatic push_hdr(logic [31:0] spill);
        t_hdr h;
        h.child = m_child;
        h.key = m_key;
        h.total = m_total;
        h.local_cnt = m_local;
        h.pstart = 17'(m_off + m_hlen);
        h.spill = spill;
        h.restarted = m_cut;
        hdr_exp_q.push_back(h);
        m_cut = 1'b0;
        m_ph = P_IDLE;
    endtask

    task automatic after_size();
        logic [63:0] loc;
        loc = stored_bytes(m_kind, m_usable, m_total);
        m_local = loc[16:0];
        if (loc < m_total) begin
            m_skip = 32'(loc);
            m_accum = 0;
            m_vidx = 0;
            m_ph = (m_skip == 0) ? P_OVF : P_SKIP;
        end else begin
            push_hdr(32'd0);
        end
    endtask

    task automatic predict_beat(t_beat bt);
        logic        done;
        logic [63:0] val;
        if (bt.start) begin
            if (m_ph != P_IDLE) m_cut = 1'b1;
            m_ph = (m_kind == KIND_TBL_INT || m_kind == KIND_IDX_INT) ? P_CHILD : P_PSIZE;
            m_accum = 0;
            m_vidx = 0;
            m_hlen = 0;
            m_off = bt.offset;
            m_child = 0;
            m_key = 0;
            m_total = 0;
            m_local = 0;
            m_skip = 0;
        end
        case (m_ph)
            P_CHILD: begin
                m_accum = (m_accum << 8) | bt.data;
                m_vidx++;
                m_hlen++;
                if (m_vidx >= 4) begin
                    m_child = m_accum[31:0];
                    m_accum = 0;
                    m_vidx = 0;
                    m_ph = (m_kind == KIND_TBL_INT) ? P_KEY : P_PSIZE;
                end
            end
            P_PSIZE, P_KEY: begin
                m_hlen++;
                if (m_vidx >= 8) begin
                    m_accum = (m_accum << 8) | bt.data;
                    done = 1'b1;
                end else begin
                    m_accum = (m_accum << 7) | bt.data[6:0];
                    m_vidx++;
                    done = !bt.data[7];
                end
                if (done) begin
                    val = m_accum;
                    m_accum = 0;
                    m_vidx = 0;
                    if (m_ph == P_PSIZE) begin
                        m_total = val;
                        if (m_kind == KIND_TBL_LEAF) m_ph = P_KEY;
                        else after_size();
                    end else begin
                        m_key = val;
                        if (m_kind == KIND_TBL_INT) push_hdr(32'd0);
                        else after_size();
                    end
                end
            end
            P_SKIP: begin
                if (m_skip > 0) m_skip--;
                if (m_skip == 0) m_ph = P_OVF;
            end
            P_OVF: begin
                m_accum = (m_accum << 8) | bt.data;
                m_vidx++;
                if (m_vidx >= 4) push_hdr(m_accum[31:0]);
            end
            default: ;
        endcase
    endtask

    // sender
    always @(posedge i_clk) begin
        t_beat cur;
        t_beat nxt;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                cur.data = i_data_byte;
                cur.start = i_cell_start;
                cur.offset = i_cell_offset;
                predict_beat(cur);
            end
            if (!i_valid || !o_stall) begin
                if (beat_q.size() > 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
                    nxt = beat_q.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_cell_start <= nxt.start;
                    i_cell_offset <= nxt.offset;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_hdr e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (hdr_exp_q.size() == 0) begin
                    $display("%0t unexpected header beat child %h key %h", $time,
                             o_child_page, o_row_key);
                    errors++;
                end else begin
                    e = hdr_exp_q.pop_front();
                    if (o_child_page !== e.child) begin
                        $display("%0t child_page exp %h got %h", $time, e.child, o_child_page);
                        errors++;
                    end
                    if (o_row_key !== e.key) begin
                        $display("%0t row_key exp %h got %h", $time, e.key, o_row_key);
                        errors++;
                    end
                    if (o_payload_total !== e.total) begin
                        $display("%0t payload_total exp %h got %h", $time, e.total,
                                 o_payload_total);
                        errors++;
                    end
                    if (o_local_count !== e.local_cnt) begin
                        $display("%0t local_count exp %0d got %0d", $time, e.local_cnt,
                                 o_local_count);
                        errors++;
                    end
                    if (o_payload_start !== e.pstart) begin
                        $display("%0t payload_start exp %0d got %0d", $time, e.pstart,
                                 o_payload_start);
                        errors++;
                    end
                    if (o_spill_page !== e.spill) begin
                        $display("%0t spill_page exp %h got %h", $time, e.spill, o_spill_page);
                        errors++;
                    end
                    if (o_restarted !== e.restarted) begin
                        $display("%0t restarted exp %b got %b", $time, e.restarted,
                                 o_restarted);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99, 0) < rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 3000000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_beat(logic [7:0] d, logic s, logic [15:0] off);
        t_beat bt;
        bt.data = d;
        bt.start = s;
        bt.offset = off;
        beat_q.push_back(bt);
        phase_beats++;
    endtask

    // random varint with n bytes, continuation bits forced to match n
    task automatic make_varint(ref logic [7:0] vb[$], input int n);
        logic [7:0] b;
        vb = {};
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom());
            if (i < 8) b[7] = (i < n - 1);
            vb.push_back(b);
        end
    endtask

    function automatic logic [63:0] varint_value(logic [7:0] vb[$]);
        logic [63:0] a;
        a = 0;
        foreach (vb[i]) begin
            if (i >= 8) a = (a << 8) | vb[i];
            else a = (a << 7) | vb[i][6:0];
        end
        return a;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 45) return 1;
        if (r < 80) return 2;
        if (r < 90) return 3;
        return $urandom_range(9, 4);
    endfunction

    // one cell: header, local payload and overflow pointer when it spills, then up to
    // three trailing bytes; cut=1 drops the tail of a header longer than one byte
    task automatic add_cell(logic [1:0] kind, logic [16:0] usz, logic cut);
        logic [7:0]  hdr[$];
        logic [7:0]  vb[$];
        logic [63:0] p;
        logic [63:0] loc;
        int          n;
        hdr = {};
        p = 0;
        if (kind == KIND_TBL_INT || kind == KIND_IDX_INT)
            for (int i = 0; i < 4; i++) hdr.push_back(8'($urandom()));
        if (kind != KIND_TBL_INT) begin
            make_varint(vb, pick_len());
            p = varint_value(vb);
            loc = stored_bytes(kind, usz, p);
            // keep the skipped local payload short
            if (loc < p && loc > 100) begin
                vb = {8'($urandom_range(127, 0))};
                p = vb[0];
            end
            foreach (vb[i]) hdr.push_back(vb[i]);
        end
        if (kind == KIND_TBL_LEAF || kind == KIND_TBL_INT) begin
            make_varint(vb, pick_len());
            foreach (vb[i]) hdr.push_back(vb[i]);
        end
        if (cut && hdr.size() > 1) begin
            n = $urandom_range(hdr.size() - 1, 1);
            for (int i = 0; i < n; i++) add_beat(hdr[i], i == 0, 16'($urandom()));
            return;
        end
        foreach (hdr[i]) add_beat(hdr[i], i == 0, 16'($urandom()));
        loc = stored_bytes(kind, usz, p);
        if (kind != KIND_TBL_INT && loc < p) begin
            for (int i = 0; i < loc; i++) add_beat(8'($urandom()), 1'b0, 16'($urandom()));
            for (int i = 0; i < 4; i++) add_beat(8'($urandom()), 1'b0, 16'($urandom()));
        end
        n = $urandom_range(3, 0);
        for (int i = 0; i < n; i++) add_beat(8'($urandom()), 1'b0, 16'($urandom()));
    endtask

    task automatic drain();
        wait (beat_q.size() == 0 && !i_valid && hdr_exp_q.size() == 0);
        // a cut cell or trailing bytes leave no result, give the spill unit time
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] kind, logic [16:0] usz);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_PAGE_KIND;
        i_cfg_data <= 17'(kind);
        @(posedge i_clk);
        i_cfg_idx <= CFG_USABLE;
        i_cfg_data <= usz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_kind = kind;
        m_usable = usz;
    endtask

    initial begin
        logic [1:0]  kinds[9];
        logic [16:0] sizes[9];
        logic [1:0]  k;
        kinds = '{KIND_TBL_LEAF, KIND_TBL_INT, KIND_IDX_LEAF, KIND_IDX_INT, KIND_IDX_LEAF,
                  KIND_TBL_LEAF, KIND_TBL_INT, KIND_IDX_INT, KIND_TBL_LEAF};
        sizes = '{17'd480, 17'd65536, 17'd4096, 17'd480, 17'd65536,
                  17'd131071, 17'd0, 17'd1000, 17'd2048};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PAGE_KIND;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_cell_start = 1'b0;
        i_cell_offset = '0;
        i_stall = 1'b0;
        m_kind = KIND_TBL_LEAF;
        m_usable = USABLE_RESET;
        m_ph = P_IDLE;
        m_accum = 0;
        m_vidx = 0;
        m_hlen = 0;
        m_off = 0;
        m_child = 0;
        m_key = 0;
        m_total = 0;
        m_local = 0;
        m_skip = 0;
        m_cut = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b0 | 1'b1;
        @(posedge i_clk);

        // directed, reset config: stray byte, all-zero cell, cut cell, cell with 7f payload and key
        add_beat(8'hff, 1'b0, 16'hffff);
        add_beat(8'h00, 1'b1, 16'h0000);
        add_beat(8'h00, 1'b0, 16'h0000);
        add_beat(8'h81, 1'b1, 16'hffff);
        add_beat(8'h7f, 1'b1, 16'hffff);
        add_beat(8'h7f, 1'b0, 16'h0000);
        drain();
        // max 9-byte payload and key spill at the smallest page
        write_cfg(KIND_TBL_LEAF, USABLE_MIN);
        add_beat(8'hff, 1'b1, 16'hffff);
        for (int i = 0; i < 8; i++) add_beat(8'hff, 1'b0, 16'h0);
        for (int i = 0; i < 9; i++) add_beat(8'hff, 1'b0, 16'h0);
        for (int i = 0; i < stored_bytes(KIND_TBL_LEAF, USABLE_MIN, 64'hffff_ffff_ffff_ffff);
             i++)
            add_beat(8'h00, 1'b0, 16'h0);
        for (int i = 0; i < 4; i++) add_beat(8'hff, 1'b0, 16'h0);
        drain();
        for (k = KIND_TBL_INT; ; k++) begin
            write_cfg(k, USABLE_MAX);
            add_cell(k, USABLE_MAX, 1'b0);
            add_cell(k, USABLE_MAX, 1'b1);
            add_cell(k, USABLE_MAX, 1'b0);
            drain();
            if (k == KIND_IDX_INT) break;
        end

        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 3) begin
                snd_idle_pct = 9;
                rcv_idle_pct = 66;
            end else if (ph < 6) begin
                snd_idle_pct = 66;
                rcv_idle_pct = 9;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_cfg(kinds[ph], sizes[ph]);
            phase_beats = 0;
            while (phase_beats < 80) begin
                if ($urandom_range(99, 0) < 8)
                    add_beat(8'($urandom()), 1'b0, 16'($urandom()));
                add_cell(kinds[ph], sizes[ph], $urandom_range(99, 0) < 12);
            end
            drain();
        end

        if (errors == 0 && hdr_exp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
